// ----- hw/rtl/dfp_pkg.sv -----
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared types, character codes and the power-of-ten table for the decimal
// token to fixed point parser.
// ----------------------------------------------------------------------------
package dfp_pkg;

   localparam int INT_ACC_W  = 32;   // wraps; only its low 32 - FRAC_BITS bits reach the result
   localparam int FRAC_ACC_W = 30;   // holds up to 999999999
   localparam int DIGIT_W    = 4;

   localparam logic [DIGIT_W-1:0] MAX_FRAC_DIGITS = 4'd9;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic                  negative;
      logic [INT_ACC_W-1:0]  integer_acc;
      logic [FRAC_ACC_W-1:0] fraction_acc;
      logic [DIGIT_W-1:0]    fraction_digits;
   } scan_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // 10^n, counts above nine clamp to nine
   function automatic logic [FRAC_ACC_W-1:0] pow10_of(input logic [DIGIT_W-1:0] n);
      logic [FRAC_ACC_W-1:0] p;
      unique case (n)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         default: p = 30'd1000000000;
      endcase
      return p;
   endfunction

endpackage

// ----- hw/rtl/dfp_req_if.sv -----
// ----------------------------------------------------------------------------
// dfp_req_if
// Character channel: one token character and a last-of-token flag per item.
// ----------------------------------------------------------------------------
interface dfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       token_end;

   modport source (output valid, output char_in, output token_end, input ready);
   modport sink   (input valid, input char_in, input token_end, output ready);
endinterface

// ----- hw/rtl/dfp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dfp_rsp_if
// Result channel: one signed fixed point value per item.
// ----------------------------------------------------------------------------
interface dfp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] fixed_value;

   modport source (output valid, output fixed_value, input ready);
   modport sink   (input valid, input fixed_value, output ready);
endinterface

// ----- hw/rtl/dfp_scanner.sv -----
// ----------------------------------------------------------------------------
// dfp_scanner
// Per-character token scanner: blank skip, sign, integer and fraction
// digit accumulation. One character per cycle while take is high; cleared after each token.
// ----------------------------------------------------------------------------
module dfp_scanner
   import dfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] char_in,
   input  logic       clear,
   output scan_type   scan
);

   localparam logic [1:0] PH_BLANK = 2'd0;
   localparam logic [1:0] PH_INT   = 2'd1;
   localparam logic [1:0] PH_FRAC  = 2'd2;
   localparam logic [1:0] PH_STOP  = 2'd3;

   logic [1:0]            phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [INT_ACC_W-1:0]  int_ff, int_in;
   logic [FRAC_ACC_W-1:0] frac_ff, frac_in;
   logic [DIGIT_W-1:0]    digits_ff, digits_in;

   logic                  is_digit;
   logic [3:0]            digit;
   logic [INT_ACC_W-1:0]  int_next;
   logic [FRAC_ACC_W-1:0] frac_next;

   assign is_digit  = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign digit     = char_in[3:0];
   // acc * 10 + digit as shift-adds, wrapping in the kept width
   assign int_next  = (int_ff << 3) + (int_ff << 1) + INT_ACC_W'(digit);
   assign frac_next = (frac_ff << 3) + (frac_ff << 1) + FRAC_ACC_W'(digit);

   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      int_in    = int_ff;
      frac_in   = frac_ff;
      digits_in = digits_ff;
      if (clear) begin
         phase_in  = PH_BLANK;
         neg_in    = 1'b0;
         int_in    = '0;
         frac_in   = '0;
         digits_in = '0;
      end else if (take) begin
         unique case (phase_ff)
            PH_BLANK: begin
               priority if (char_in == CHAR_SPACE || char_in == CHAR_TAB) begin
                  phase_in = PH_BLANK;
               end else if (char_in == CHAR_MINUS) begin
                  neg_in   = 1'b1;
                  phase_in = PH_INT;
               end else if (char_in == CHAR_PLUS) begin
                  phase_in = PH_INT;
               end else if (is_digit) begin
                  int_in   = int_next;
                  phase_in = PH_INT;
               end else if (char_in == CHAR_DOT) begin
                  phase_in = PH_FRAC;
               end else begin
                  phase_in = PH_STOP;
               end
            end
            PH_INT: begin
               priority if (is_digit) begin
                  int_in = int_next;
               end else if (char_in == CHAR_DOT) begin
                  phase_in = PH_FRAC;
               end else begin
                  phase_in = PH_STOP;
               end
            end
            PH_FRAC: begin
               if (is_digit) begin
                  // extra fraction digits are dropped without stopping
                  if (digits_ff < MAX_FRAC_DIGITS) begin
                     frac_in   = frac_next;
                     digits_in = digits_ff + 4'd1;
                  end
               end else begin
                  phase_in = PH_STOP;
               end
            end
            PH_STOP: begin
               phase_in = PH_STOP;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_BLANK;
         neg_ff    <= 1'b0;
         int_ff    <= '0;
         frac_ff   <= '0;
         digits_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         int_ff    <= int_in;
         frac_ff   <= frac_in;
         digits_ff <= digits_in;
      end
   end

   assign scan.negative        = neg_ff;
   assign scan.integer_acc     = int_ff;
   assign scan.fraction_acc    = frac_ff;
   assign scan.fraction_digits = digits_ff;

endmodule

// ----- hw/rtl/dfp_divider.sv -----
// ----------------------------------------------------------------------------
// dfp_divider
// Restoring shift-subtract divider, one quotient bit per cycle. The dividend
// is known to be below divisor * 2^(FRAC_BITS+1), so FRAC_BITS+1 steps do.
// ----------------------------------------------------------------------------
module dfp_divider
   import dfp_pkg::*;
#(
   parameter int FRAC_BITS = 12,
   localparam int DW = FRAC_ACC_W + 1 + FRAC_BITS,
   localparam int QW = FRAC_BITS + 1,
   localparam int CW = $clog2(QW + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DW-1:0]         dividend,
   input  logic [FRAC_ACC_W-1:0] divisor,
   output div_status_type        status,
   output logic [QW-1:0]         quotient
);

   logic [FRAC_ACC_W-1:0] rem_ff, rem_in;
   logic [FRAC_ACC_W-1:0] div_ff;
   logic [QW-1:0]         low_ff, low_in;
   logic [QW-1:0]         quo_ff, quo_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  done_ff, done_in;

   logic [FRAC_ACC_W:0]   trial;
   logic [FRAC_ACC_W:0]   diff;
   logic                  fits;

   assign trial = {rem_ff, low_ff[QW-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in = fits ? diff[FRAC_ACC_W-1:0] : trial[FRAC_ACC_W-1:0];
      low_in = {low_ff[QW-2:0], 1'b0};
      quo_in = {quo_ff[QW-2:0], fits};
   end

   always_comb begin
      count_in = count_ff;
      if (start) begin
         count_in = CW'(QW);
      end else if (count_ff != '0) begin
         count_in = count_ff - CW'(1);
      end
      done_in = !start && (count_ff == CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[DW-1:QW];
         low_ff <= dividend[QW-1:0];
         div_ff <= divisor;
         quo_ff <= '0;
      end else if (count_ff != '0) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         quo_ff <= quo_in;
      end
   end

   assign status.busy = count_ff != '0;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- hw/rtl/decimal_to_fixed_parser_core.sv -----
// ----------------------------------------------------------------------------
// decimal_to_fixed_parser_core
// Decimal token to signed fixed point converter.
// ----------------------------------------------------------------------------
// req_ch carries one character per item with token_end on the last one of a
// token; rsp_ch returns one signed value with FRAC_BITS fraction bits per
// token. Characters are taken one per cycle while the scanner is running.
// After the last character ready drops while the token is finished, which
// runs through the start, sum and output states; with fraction digits a
// divide state lies between start and sum, for the shift-subtract
// divider that rounds the fraction, one bit a cycle.
// ready returns the cycle after the result is loaded. The output register
// holds a result while rsp_ch stalls; the next token's characters are still
// taken, and only its own finish waits for the register to drain.
// Reset returns the scanner to blank skip with all accumulators cleared and
// empties the output register.
// ----------------------------------------------------------------------------
module decimal_to_fixed_parser_core
   import dfp_pkg::*;
#(
   parameter int FRAC_BITS = 12
) (
   input logic         clock,
   input logic         reset,
   dfp_req_if.sink     req_ch,
   dfp_rsp_if.source   rsp_ch
);

   localparam int DW = FRAC_ACC_W + 1 + FRAC_BITS;
   localparam int QW = FRAC_BITS + 1;

   localparam logic [2:0] ST_PARSE  = 3'd0;
   localparam logic [2:0] ST_START  = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_SUM    = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic                  out_valid_ff, out_valid_in;
   logic [31:0]           out_value_ff;
   logic [31:0]           sum_ff, sum_in;

   logic                  accept;
   logic                  out_load;
   logic                  div_start;
   scan_type              scan;
   div_status_type        div_st;
   logic [QW-1:0]         quotient;
   logic [FRAC_ACC_W-1:0] pow10;
   logic [DW-1:0]         dividend;
   logic [31:0]           frac_term;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_load = (state_ff == ST_OUT) && (!out_valid_ff || rsp_ch.ready);

   dfp_scanner u_scanner (
      .clock   (clock),
      .reset   (reset),
      .take    (accept),
      .char_in (req_ch.char_in),
      .clear   (out_load),
      .scan    (scan)
   );

   // (fraction << FRAC_BITS) + 10^digits / 2 gives round-half-up
   assign pow10     = pow10_of(scan.fraction_digits);
   assign dividend  = (DW'(scan.fraction_acc) << FRAC_BITS) + DW'(pow10 >> 1);
   assign div_start = (state_ff == ST_START) && (scan.fraction_digits != '0);

   dfp_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (pow10),
      .status   (div_st),
      .quotient (quotient)
   );

   assign frac_term = (scan.fraction_digits == '0) ? 32'd0 : 32'(quotient);
   assign sum_in    = (scan.integer_acc << FRAC_BITS) + frac_term;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_PARSE: begin
            if (accept && req_ch.token_end) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = div_start ? ST_DIVIDE : ST_SUM;
         end
         ST_DIVIDE: begin
            if (div_st.done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_PARSE;
            end
         end
         default: begin
            state_in = ST_PARSE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PARSE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         sum_ff <= sum_in;
      end
      if (out_load) begin
         out_value_ff <= scan.negative ? (32'd0 - sum_ff) : sum_ff;
      end
   end

   assign req_ch.ready       = state_ff == ST_PARSE;
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.fixed_value = $signed(out_value_ff);

   // the sequencer leaves parsing right after a token's last character
   a_end_drops_ready: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.token_end) |=> !req_ch.ready)
      else $error("ready still high after last character of a token");

   // divider is running or finishing whenever the sequencer waits on it
   a_divide_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (div_st.busy || div_st.done))
      else $error("waiting on an idle divider");

   // rounded fraction never exceeds one unit of the integer part
   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (quotient <= (QW'(1) << FRAC_BITS)))
      else $error("fraction quotient out of range");

   // a new result only appears from the output stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result raised outside the output stage");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives decimal tokens one character per item into the parser core and checks
// every fixed point result against a cycle-free model of the token scanner,
// under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb
   import dfp_pkg::*;
;

   localparam int FRAC_BITS   = 12;
   localparam int CYCLE_LIMIT = 400000;
   localparam int QUIET_TAIL  = 200;   // no new random gaps once at most this many items remain
   localparam int DRAIN_WAIT  = 40;    // longer than the finish of a token with fraction digits

   typedef enum logic [2:0] {
      SCAN_BLANK,
      SCAN_INT,
      SCAN_FRAC,
      SCAN_STOP
   } scan_phase_type;

   typedef struct {
      logic [7:0] code;
      logic       last;
      bit         drain;   // wait for all results before sending this item
   } char_item_type;

   logic clock;
   logic reset;

   dfp_req_if req_ch ();
   dfp_rsp_if rsp_ch ();

   decimal_to_fixed_parser_core #(
      .FRAC_BITS(FRAC_BITS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   char_item_type      char_queue[$];
   logic signed [31:0] fixed_expected[$];

   // scanner copy
   scan_phase_type  scan_phase;
   logic            scan_negative;
   logic [63:0]     scan_int;
   logic [29:0]     scan_frac;
   logic [3:0]      scan_digits;

   int  error_count;
   int  chars_accepted;
   int  cycle_count;
   int  send_gap;
   int  recv_gap;
   int  hold_count;
   bit  hold_used;
   logic long_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   task automatic scan_clear();
      scan_phase    = SCAN_BLANK;
      scan_negative = 1'b0;
      scan_int      = '0;
      scan_frac     = '0;
      scan_digits   = '0;
   endtask

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.char_in    = 8'h00;
      req_ch.token_end  = 1'b0;
      rsp_ch.ready      = 1'b0;
      long_hold         = 1'b0;
      error_count       = 0;
      chars_accepted    = 0;
      cycle_count       = 0;
      send_gap          = 0;
      recv_gap          = 0;
      hold_count        = 0;
      hold_used         = 0;
      scan_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [31:0] token_fixed_value();
      logic [63:0] divisor;
      logic [63:0] frac_part;
      logic [63:0] total;
      int          i;
      frac_part = '0;
      if (scan_digits != 0) begin
         divisor = 64'd1;
         for (i = 0; i < int'(scan_digits); i++) divisor = divisor * 64'd10;
         frac_part = (({34'd0, scan_frac} << FRAC_BITS) + (divisor >> 1)) / divisor;
      end
      total = (scan_int << FRAC_BITS) + frac_part;
      if (scan_negative) total = 64'd0 - total;
      return total[31:0];
   endfunction

   task automatic scan_char(input logic [7:0] c, input logic last);
      case (scan_phase)
         SCAN_BLANK: begin
            if (c == CHAR_SPACE || c == CHAR_TAB) begin
               scan_phase = SCAN_BLANK;
            end else if (c == CHAR_MINUS) begin
               scan_negative = 1'b1;
               scan_phase    = SCAN_INT;
            end else if (c == CHAR_PLUS) begin
               scan_phase = SCAN_INT;
            end else if (is_digit(c)) begin
               scan_int   = scan_int * 64'd10 + 64'(c - CHAR_ZERO);
               scan_phase = SCAN_INT;
            end else if (c == CHAR_DOT) begin
               scan_phase = SCAN_FRAC;
            end else begin
               scan_phase = SCAN_STOP;
            end
         end
         SCAN_INT: begin
            if (is_digit(c)) scan_int = scan_int * 64'd10 + 64'(c - CHAR_ZERO);
            else if (c == CHAR_DOT) scan_phase = SCAN_FRAC;
            else scan_phase = SCAN_STOP;
         end
         SCAN_FRAC: begin
            if (is_digit(c)) begin
               // extra fraction digits are dropped but do not stop the scan
               if (scan_digits < MAX_FRAC_DIGITS) begin
                  scan_frac   = scan_frac * 30'd10 + 30'(c - CHAR_ZERO);
                  scan_digits = scan_digits + 4'd1;
               end
            end else begin
               scan_phase = SCAN_STOP;
            end
         end
         default: scan_phase = SCAN_STOP;
      endcase
      if (last) begin
         fixed_expected.push_back(token_fixed_value());
         scan_clear();
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic queue_token(input logic [7:0] tok[$], input bit drain);
      char_item_type item;
      int            i;
      for (i = 0; i < tok.size(); i++) begin
         item.code  = tok[i];
         item.last  = (i == tok.size() - 1);
         item.drain = drain && (i == 0);
         char_queue.push_back(item);
      end
   endtask

   task automatic queue_text(input string s);
      logic [7:0] tok[$];
      int         i;
      for (i = 0; i < s.len(); i++) tok.push_back(s[i]);
      queue_token(tok, 1'b0);
   endtask

   function automatic logic [7:0] rand_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   task automatic queue_random_token(input bit drain);
      logic [7:0] tok[$];
      int         kind;
      int         n;
      int         i;
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
         // noise
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) tok.push_back(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(0, 3);
         for (i = 0; i < n && $urandom_range(0, 1) == 1; i++)
            tok.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
         case ($urandom_range(0, 2))
            1: tok.push_back(CHAR_MINUS);
            2: tok.push_back(CHAR_PLUS);
            default: ;
         endcase
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 22) : $urandom_range(0, 6);
         for (i = 0; i < n; i++) tok.push_back(rand_digit());
         if ($urandom_range(0, 9) < 7) begin
            tok.push_back(CHAR_DOT);
            n = $urandom_range(0, 11);
            for (i = 0; i < n; i++) tok.push_back(rand_digit());
         end
         if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) tok.push_back(8'($urandom_range(0, 255)));
         end
         if (tok.size() == 0) tok.push_back(rand_digit());
         // broken sequence: one character overwritten
         if (kind < 4) tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom_range(0, 255));
      end
      queue_token(tok, drain);
   endtask

   initial begin
      logic [7:0] tok[$];
      int         ntok;

      queue_text(" \t-12.5");
      queue_text("+0");
      queue_text("7");
      queue_text("-");
      queue_text(".");
      queue_text("   ");
      queue_text("x5");
      queue_text("- 5");
      queue_text("--5");
      queue_text("1.2.3");
      queue_text("+-3");
      queue_text("1.5e3");
      queue_text("0.1234567891234");
      queue_text(".000000001");
      queue_text("-.999999999");
      queue_text("524287.999999999");
      queue_text("-524288");
      queue_text("99999999999999999999999");
      queue_text("18446744073709551615.5");
      tok = '{8'h00, CHAR_ZERO + 8'd7};
      queue_token(tok, 1'b0);
      tok = '{CHAR_ZERO + 8'd4, 8'h00, CHAR_ZERO + 8'd9};
      queue_token(tok, 1'b0);
      tok = '{CHAR_ZERO + 8'd3, 8'hFF};
      queue_token(tok, 1'b0);
      tok = '{8'hFF};
      queue_token(tok, 1'b0);

      ntok = 0;
      while (char_queue.size() < 1550) begin
         queue_random_token(ntok % 40 == 0);
         ntok++;
      end

      while (reset) @(posedge clock);
      while (char_queue.size() != 0 || req_ch.valid || fixed_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // ------------------------------------------------------------------ driver

   always @(posedge clock) begin
      char_item_type item;
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.char_in   <= 8'h00;
         req_ch.token_end <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            scan_char(req_ch.char_in, req_ch.token_end);
            chars_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (char_queue.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (char_queue[0].drain && fixed_expected.size() != 0) begin
               req_ch.valid <= 1'b0;
            end else if (char_queue.size() > QUIET_TAIL && $urandom_range(0, 15) == 0) begin
               send_gap = $urandom_range(0, 8);
               req_ch.valid <= 1'b0;
            end else begin
               item = char_queue.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.char_in   <= item.code;
               req_ch.token_end <= item.last;
            end
         end
      end
   end

   // ----------------------------------------------------------------- monitor

   always @(posedge clock) begin
      logic signed [31:0] want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (fixed_expected.size() == 0) begin
               $error("fixed_value unexpected: expected none, actual %0d", rsp_ch.fixed_value);
               error_count++;
            end else begin
               want = fixed_expected.pop_front();
               if (rsp_ch.fixed_value !== want) begin
                  $error("fixed_value mismatch: expected %0d, actual %0d",
                         want, rsp_ch.fixed_value);
                  error_count++;
               end
            end
         end
         if (recv_gap != 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (long_hold) begin
            rsp_ch.ready <= 1'b0;
         end else if (char_queue.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
            recv_gap = $urandom_range(0, 8);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // one long receiver stall so the output register fills and input backs up
   always @(posedge clock) begin
      if (reset) begin
         long_hold <= 1'b0;
         hold_count = 0;
      end else if (long_hold) begin
         if (hold_count == 0) long_hold <= 1'b0;
         else hold_count--;
      end else if (!hold_used && chars_accepted >= 300) begin
         long_hold <= 1'b1;
         hold_count = 250;
         hold_used  = 1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule

// ----- sim.f -----
hw/rtl/dfp_pkg.sv
hw/rtl/dfp_req_if.sv
hw/rtl/dfp_rsp_if.sv
hw/rtl/dfp_scanner.sv
hw/rtl/dfp_divider.sv
hw/rtl/decimal_to_fixed_parser_core.sv
tb/sv/tb.sv
